FILE: src/gbp_pkg.sv
// ----------------------------------------------------------------------------
// gbp_pkg: shared types and constants for the Goertzel bin power block
// Command and status groups between controller and datapath, multiplier
// operand selects and configuration register indexes.
// ----------------------------------------------------------------------------
package gbp_pkg;

  localparam int unsigned Q_SHIFT   = 14;
  localparam int unsigned ACC_W     = 32;  // feedback word width
  localparam int unsigned COEF_W    = 16;
  localparam int unsigned BLEN_W    = 16;
  localparam int unsigned POWER_W   = 64;
  localparam int unsigned SCALED_W  = 34;  // (coef * s1) >> 14 at full width
  localparam int unsigned MUL_A_W   = SCALED_W;
  localparam int unsigned MUL_B_W   = ACC_W;
  localparam int unsigned PROD_W    = MUL_A_W + MUL_B_W;
  localparam int unsigned CFG_IDX_W = 1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_COEFFICIENT  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_LENGTH = 1'b1;

  // operand selects of the shared multiplier
  typedef logic [1:0] mul_sel_t;
  localparam mul_sel_t MUL_COEF_S1 = 2'd0;  // coefficient * s1
  localparam mul_sel_t MUL_S1_S1   = 2'd1;  // s1 * s1
  localparam mul_sel_t MUL_S2_S2   = 2'd2;  // s2 * s2
  localparam mul_sel_t MUL_CS1_S2  = 2'd3;  // scaled s1 * s2

  typedef struct packed {
    logic     accept;   // request taken this cycle
    logic     mul_en;   // load product register
    mul_sel_t mul_sel;
    logic     upd;      // recurrence step: s0, shift feedback, count
    logic     cs1_ld;   // capture scaled s1 from product
    logic     acc_ld;   // acc <= product
    logic     acc_add;  // acc <= acc + product
    logic     fin;      // result register <= acc - product, clear block state
  } gbp_cmd_t;

  typedef struct packed {
    logic block_done;   // count after this step reaches the block length
  } gbp_sts_t;

endpackage

FILE: src/gbp_dp.sv
// ----------------------------------------------------------------------------
// gbp_dp: Goertzel datapath
// Feedback registers, sample counter, configuration registers, one shared
// registered multiplier, accumulator and the result register.
// ----------------------------------------------------------------------------
module gbp_dp
  import gbp_pkg::*;
#(
  parameter int unsigned SAMPLE_WIDTH = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_addr,
  input  logic [BLEN_W-1:0]       cfg_wdata,
  input  logic [SAMPLE_WIDTH-1:0] sample,
  input  logic                    restart,
  input  gbp_cmd_t                cmd,
  output gbp_sts_t                sts,
  output logic [POWER_W-1:0]      power
);

  logic signed [COEF_W-1:0]   coef_r;
  logic        [BLEN_W-1:0]   blen_r;
  logic signed [ACC_W-1:0]    x_r, s1_r, s2_r;
  logic signed [ACC_W-1:0]    s0;
  logic        [BLEN_W-1:0]   cnt_r, cnt_inc, limit;
  logic signed [SCALED_W-1:0] cs1_r;
  logic signed [MUL_A_W-1:0]  mul_a;
  logic signed [MUL_B_W-1:0]  mul_b;
  logic signed [PROD_W-1:0]   prod_r;
  logic        [POWER_W-1:0]  acc_r;
  logic        [POWER_W-1:0]  power_r;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r <= '0;
      blen_r <= BLEN_W'(64);
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_COEFFICIENT:  coef_r <= cfg_wdata;
        REG_BLOCK_LENGTH: blen_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // shared multiplier operand mux
  always_comb begin
    unique case (cmd.mul_sel)
      MUL_COEF_S1: begin
        mul_a = MUL_A_W'(coef_r);
        mul_b = s1_r;
      end
      MUL_S1_S1: begin
        mul_a = MUL_A_W'(s1_r);
        mul_b = s1_r;
      end
      MUL_S2_S2: begin
        mul_a = MUL_A_W'(s2_r);
        mul_b = s2_r;
      end
      default: begin
        mul_a = cs1_r;
        mul_b = s2_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) prod_r <= mul_a * mul_b;
  end

  // recurrence: shifted product truncated to 32 bits, sum wraps
  assign s0      = x_r + prod_r[Q_SHIFT +: ACC_W] - s2_r;
  assign cnt_inc = cnt_r + BLEN_W'(1);
  assign limit   = (blen_r == '0) ? BLEN_W'(1) : blen_r;
  assign sts.block_done = (cnt_inc >= limit);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r  <= '0;
      s2_r  <= '0;
      cnt_r <= '0;
    end else if (cmd.accept && restart) begin
      s1_r  <= '0;
      s2_r  <= '0;
      cnt_r <= '0;
    end else if (cmd.upd) begin
      s2_r  <= s1_r;
      s1_r  <= s0;
      cnt_r <= cnt_inc;
    end else if (cmd.fin) begin
      s1_r  <= '0;
      s2_r  <= '0;
      cnt_r <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) x_r <= ACC_W'(signed'(sample));
    if (cmd.cs1_ld) cs1_r <= prod_r[Q_SHIFT +: SCALED_W];
    if (cmd.acc_ld) acc_r <= prod_r[POWER_W-1:0];
    else if (cmd.acc_add) acc_r <= acc_r + prod_r[POWER_W-1:0];
    if (cmd.fin) power_r <= acc_r - prod_r[POWER_W-1:0];
  end

  assign power = power_r;

endmodule

FILE: src/gbp_ctrl.sv
// ----------------------------------------------------------------------------
// gbp_ctrl: Goertzel sequencer
// Steps each sample through the shared multiplier, runs the end-of-block
// products and owns the result valid flag.
// ----------------------------------------------------------------------------
module gbp_ctrl
  import gbp_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  gbp_sts_t sts,
  output gbp_cmd_t cmd
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MULC  = 3'd1;
  localparam logic [2:0] ST_UPD   = 3'd2;
  localparam logic [2:0] ST_ENDC  = 3'd3;
  localparam logic [2:0] ST_SQ1   = 3'd4;
  localparam logic [2:0] ST_SQ2   = 3'd5;
  localparam logic [2:0] ST_CROSS = 3'd6;
  localparam logic [2:0] ST_FIN   = 3'd7;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    cmd.mul_sel = MUL_COEF_S1;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = ST_MULC;
        end
      end
      ST_MULC: begin
        cmd.mul_en = 1'b1;
        state_nxt  = ST_UPD;
      end
      ST_UPD: begin
        cmd.upd   = 1'b1;
        state_nxt = sts.block_done ? ST_ENDC : ST_IDLE;
      end
      ST_ENDC: begin
        cmd.mul_en = 1'b1;
        state_nxt  = ST_SQ1;
      end
      ST_SQ1: begin
        cmd.cs1_ld  = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_S1_S1;
        state_nxt   = ST_SQ2;
      end
      ST_SQ2: begin
        cmd.acc_ld  = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_S2_S2;
        state_nxt   = ST_CROSS;
      end
      ST_CROSS: begin
        cmd.acc_add = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_CS1_S2;
        state_nxt   = ST_FIN;
      end
      ST_FIN: begin
        // hold until the result register is free
        if (!out_valid_r || out_ready) begin
          cmd.fin   = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ready) out_valid_nxt = 1'b0;
    if (cmd.fin)   out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

FILE: src/goertzel_bin_power.sv
// ----------------------------------------------------------------------------
// goertzel_bin_power: single-bin Goertzel power detector, Q14 coefficient
//
// Input stream: one request per sample; in_tdata carries the sample in its
// low SAMPLE_WIDTH bits, in_tuser the restart flag, which drops any partial
// block before the sample is used. After block_length samples the block
// puts the 64-bit squared magnitude on the output stream and starts a
// fresh block.
// Steps: a sample that does not close a block passes through accept,
// multiply and update. A closing sample then goes on: the one shared
// 34x32 multiplier computes coefficient*s1, then s1*s1, s2*s2 and the
// cross term in turn, and the result is registered once the output
// register is free.
// Stalls: the result sits in an output register; new samples are taken
// while it waits. Only the next block end waits for out_tready.
// Configuration: cfg_we/cfg_addr/cfg_wdata write coefficient (index 0)
// and block_length (index 1, zero acts as one); write only while idle.
// Reset (rst_n low, synchronous): feedback and count cleared, coefficient
// 0, block_length 64, no result pending.
// ----------------------------------------------------------------------------
module goertzel_bin_power
  import gbp_pkg::*;
#(
  parameter int unsigned SAMPLE_WIDTH = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [CFG_IDX_W-1:0]           cfg_addr,
  input  logic [BLEN_W-1:0]              cfg_wdata,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0] in_tdata,  // sample
  input  logic                           in_tuser,     // restart
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [POWER_W-1:0]             out_tdata     // power
);

  gbp_cmd_t cmd;
  gbp_sts_t sts;

  gbp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  gbp_dp #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .sample    (in_tdata[SAMPLE_WIDTH-1:0]),
    .restart   (in_tuser),
    .cmd       (cmd),
    .sts       (sts),
    .power     (out_tdata)
  );

endmodule
